FILE: rtl/dnf_pkg.sv
// ---------------------------------------------------------------------------
// dnf_pkg
// Shared types for the distinct nonzero filter: item payloads and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package dnf_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_item;

    typedef struct packed {
        logic                      kept;
        logic signed [VALUE_W-1:0] value_out;
        logic [POS_W-1:0]          position;
        logic                      last_out;
        logic                      overflow;
    } t_out_item;

    typedef struct packed {
        logic load;    // capture the input transaction, restart the scan
        logic issue;   // scan step: read the next table entry
        logic commit;  // decide, update table and count, load the output
    } t_dp_cmd;

    typedef struct packed {
        logic hit;        // value matched a stored entry
        logic scan_done;  // all entries below the count compared, or none for a zero value
        logic out_free;   // output register can take a result
    } t_dp_status;

endpackage

FILE: rtl/dnf_ctrl.sv
// ---------------------------------------------------------------------------
// dnf_ctrl
// Controller: accepts one transaction, steps the table scan until a match
// or the end of the valid entries, then commits the result.
// ---------------------------------------------------------------------------
module dnf_ctrl
    import dnf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_WRITE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit || i_sts.scan_done) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            S_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/dnf_dpath.sv
// ---------------------------------------------------------------------------
// dnf_dpath
// Datapath: value table memory, distinct count, scan index with registered
// read and compare, and the output register.
// ---------------------------------------------------------------------------
module dnf_dpath
    import dnf_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_sts,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0] r_mem [CAPACITY];

    t_in_item           r_item;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [CW-1:0]      r_idx;
    logic               r_rd_pend;
    logic [VALUE_W-1:0] r_rd_data;
    logic               r_hit;
    logic               r_out_valid;
    t_out_item          r_out_item;
    t_out_item          n_out_item;

    logic [CW-1:0] w_limit;
    logic          w_more;
    logic          w_issue;
    logic          w_new;
    logic          w_room;
    logic          w_store;

    // zero never searches and never stores
    assign w_limit = (r_item.value == '0) ? '0 : r_count;
    assign w_more  = r_idx < w_limit;
    assign w_issue = i_cmd.issue && w_more && !r_hit;
    assign w_new   = (r_item.value != '0) && !r_hit;
    assign w_room  = r_count < CW'(CAPACITY);
    assign w_store = i_cmd.commit && w_new && w_room;

    assign o_sts.hit       = r_hit;
    assign o_sts.scan_done = !w_more && !r_rd_pend;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_item           = '0;
        n_out_item.value_out = r_item.value;
        n_out_item.last_out  = r_item.last;
        n_count              = r_count;
        if (w_new && w_room) begin
            n_out_item.kept     = 1'b1;
            n_out_item.position = POS_W'(r_count);
            n_count             = r_count + CW'(1);
        end else if (w_new) begin
            n_out_item.overflow = 1'b1;
        end
        if (r_item.last) begin
            n_count = '0;
        end
    end

    // table memory: a write at commit for a new value with room, one registered read per scan step
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_count[AW-1:0]] <= $unsigned(r_item.value);
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.commit) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_pend   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= w_issue;
            if (i_cmd.load) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (w_issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_rd_pend && (r_rd_data == $unsigned(r_item.value))) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_count <= n_count;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/distinct_nonzero_filter.sv
// ---------------------------------------------------------------------------
// distinct_nonzero_filter
// Flags zeros and repeats in a set of signed integers as not kept, stores
// each new value in a table while room lasts, reports its position; last ends the set.
// ---------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_in_item  (t_in_item)
//  out      output     o_out_valid / i_out_ready o_out_item (t_out_item)
//
//  one transaction is handled at a time, from accept through the scan to the
//  commit; nothing is compared for a zero value or an empty table, and the
//  scan stops early on a match: the table is one memory with one read port,
//  compared one entry per cycle through a registered read
//  synchronous active-low reset clears count and control; the table is not
//  cleared, only entries below the count are ever read
//  a stalled output holds the result in the output register; the next
//  transaction is accepted and scanned meanwhile
// ---------------------------------------------------------------------------
module distinct_nonzero_filter
    import dnf_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_cmd    s_cmd;
    t_dp_status s_sts;

    dnf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    dnf_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // an accepted transaction keeps the input closed while it is scanned
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted transaction");

    // a result is committed only once the scan has finished
    a_commit_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.commit |-> (s_sts.hit || s_sts.scan_done))
        else $error("commit before the table scan finished");

    // a commit always presents a result next cycle
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.commit |=> o_out_valid)
        else $error("commit did not load the output register");

    // a kept value cannot also report overflow
    a_kept_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.kept && o_out_item.overflow))
        else $error("result both kept and overflowed");

endmodule

FILE: tb/distinct_nonzero_filter_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// distinct_nonzero_filter_tb
// Feeds sets of signed integers through the filter with random gaps and
// stalls on both channels. A local model of the seen-value table predicts
// each result, and every result is checked field by field in arrival order.
// ---------------------------------------------------------------------------
module distinct_nonzero_filter_tb
    import dnf_pkg::*;
();

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 4 * (CAPACITY + 3);
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;
    localparam int POOL_MAX     = 128;

    localparam logic [VALUE_W-1:0] VALUE_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_NEG1 = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_ONE  = 32'h0000_0001;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // local copy of the seen-value table
    logic [VALUE_W-1:0] seen_vals [CAPACITY];
    int                 seen_count = 0;
    t_out_item          pending_verdicts [$];

    logic [VALUE_W-1:0] value_pool [POOL_MAX];
    int                 pool_count   = 0;
    bit                 idle_on      = 1'b1;
    int                 hold_request = 0;
    int                 stall_left   = 0;
    int                 error_count  = 0;
    int                 cycle_count  = 0;

    distinct_nonzero_filter #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_out_item classify_item(t_in_item item);
        t_out_item res;
        logic      found;
        res           = '0;
        found         = 1'b0;
        res.value_out = item.value;
        res.last_out  = item.last;
        if (item.value != '0) begin
            for (int k = 0; k < seen_count; k++) begin
                if (seen_vals[k] == item.value) found = 1'b1;
            end
            if (!found) begin
                if (seen_count < CAPACITY) begin
                    seen_vals[seen_count] = item.value;
                    res.kept              = 1'b1;
                    res.position          = POS_W'(seen_count);
                    seen_count++;
                end else begin
                    res.overflow = 1'b1;
                end
            end
        end
        if (item.last) seen_count = 0;
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 12) begin
            case ($urandom_range(0, 3))
                0:       return VALUE_MIN;
                1:       return VALUE_MAX;
                2:       return VALUE_NEG1;
                default: return VALUE_ONE;
            endcase
        end
        if (r < 60 && pool_count > 0) return value_pool[$urandom_range(0, pool_count - 1)];
        return $urandom();
    endfunction

    task automatic send_item(input logic [VALUE_W-1:0] v, input logic last);
        int       gap;
        t_in_item item;
        gap        = idle_on ? pick_gap() : 0;
        item.value = v;
        item.last  = last;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        pending_verdicts.push_back(classify_item(item));
    endtask

    // called right after a transaction, so valid drops in that same step
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    task automatic check_verdict(input t_out_item got);
        t_out_item want;
        if (pending_verdicts.size() == 0) begin
            if (error_count < MAX_REPORTS)
                $display("unexpected result: value=%0d kept=%0b", got.value_out, got.kept);
            error_count++;
            return;
        end
        want = pending_verdicts.pop_front();
        if (got.kept !== want.kept || got.value_out !== want.value_out
                || got.position !== want.position || got.last_out !== want.last_out
                || got.overflow !== want.overflow) begin
            if (error_count < MAX_REPORTS) begin
                $display("mismatch: expected kept=%0b value=%0d pos=%0d last=%0b ovf=%0b",
                         want.kept, want.value_out, want.position, want.last_out,
                         want.overflow);
                $display("          actual   kept=%0b value=%0d pos=%0d last=%0b ovf=%0b",
                         got.kept, got.value_out, got.position, got.last_out, got.overflow);
            end
            error_count++;
        end
    endtask

    // receiver: checks each transaction and decides the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) check_verdict(out_item);
        if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 99) < 25) begin
            out_ready <= 1'b0;
            stall_left = pick_gap();
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_verdicts.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic test_directed();
        send_item('0, 1'b0);             // zero opening a set
        send_item(VALUE_MIN, 1'b0);
        send_item(VALUE_MAX, 1'b0);
        send_item(VALUE_NEG1, 1'b0);
        send_item(VALUE_ONE, 1'b0);
        send_item(VALUE_MIN, 1'b0);      // repeat
        send_item('0, 1'b0);
        send_item(VALUE_MAX, 1'b0);
        send_item(32'h5555_5555, 1'b0);
        send_item(32'hAAAA_AAAA, 1'b0);
        send_item(VALUE_NEG1, 1'b1);     // repeat closing the set
        send_item(VALUE_NEG1, 1'b1);     // new again after the clear
        send_item('0, 1'b1);             // set of a lone zero
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b1);
        send_item(32'd5, 1'b0);
        send_item(32'd7, 1'b1);
        wait_drained();
    endtask

    task automatic test_table_full();
        logic [VALUE_W-1:0] base;
        // low six bits index the entry, bit 6 keeps every value nonzero
        base    = ($urandom() | 32'h40) & ~32'h3F;
        idle_on = 1'b0;
        for (int k = 0; k < CAPACITY; k++) send_item(base | k, 1'b0);
        idle_on = 1'b1;
        send_item(base ^ VALUE_MIN, 1'b0);           // new value, table full
        send_item((base ^ VALUE_MIN) | 1, 1'b0);
        send_item(base, 1'b0);                       // repeat while full
        send_item(base | (CAPACITY - 1), 1'b0);
        send_item('0, 1'b0);
        send_item(base ^ 32'h4000_0000, 1'b1);       // overflow on the closing item
        send_item(base, 1'b1);
        base = (~base | 32'h40) & ~32'h3F;
        for (int k = 0; k < CAPACITY; k++) send_item(base | k, k == CAPACITY - 1);
        wait_drained();
    endtask

    // long output stall while the sender keeps offering, so the input backs up
    task automatic test_backpressure();
        idle_on      = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int k = 0; k < 24; k++) begin
            if (k % 6 == 5) send_item('0, 1'b0);
            else send_item($urandom_range(1, 9), k == 11 || k == 23);
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_sets();
        int sent;
        int len;
        int kind;
        bit last_flag;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind    = $urandom_range(0, 99);
            idle_on = ($urandom_range(0, 3) != 0);
            if (kind < 65) begin
                len        = $urandom_range(1, 16);
                pool_count = $urandom_range(1, 8);
            end else if (kind < 82) begin
                len        = $urandom_range(17, 50);
                pool_count = $urandom_range(8, 40);
            end else if (kind < 94) begin
                // enough distinct values to run past the table size
                len        = $urandom_range(80, 110);
                pool_count = $urandom_range(CAPACITY, POOL_MAX - 1);
            end else begin
                len        = $urandom_range(1, 12);
                pool_count = $urandom_range(0, 4);
            end
            for (int k = 0; k < pool_count; k++) value_pool[k] = $urandom();
            for (int k = 0; k < len; k++) begin
                // noise sets end at random points
                last_flag = (kind >= 94) ? ($urandom_range(0, 1) == 1) : (k == len - 1);
                send_item(pick_value(), last_flag);
                sent++;
            end
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random_sets();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_verdicts.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
